[rtl/core/urtf_pkg.sv]
// Package for the buffered serial port FIFO block: depth constants,
// event codes, transaction payload types and ring status struct.
// No dependencies.
package urtf_pkg;

  // Ring geometry; one slot always stays empty
  localparam int unsigned FIFO_DEPTH = 128;
  localparam int unsigned PTR_W      = $clog2(FIFO_DEPTH);

  // Event codes carried in the func field
  localparam logic [1:0] FN_HOST_WR  = 2'd0;
  localparam logic [1:0] FN_HOST_RD  = 2'd1;
  localparam logic [1:0] FN_LINE_RX  = 2'd2;
  localparam logic [1:0] FN_TX_READY = 2'd3;

  // Input transaction
  typedef struct packed {
    logic [1:0] func;
    logic [7:0] data_in;
    logic       frame_error;
    logic       overrun_error;
    logic       parity_error;
  } urtf_in_t;

  // Result transaction
  typedef struct packed {
    logic       accepted;
    logic [7:0] rx_data;
    logic       tx_valid;
    logic [7:0] tx_data;
    logic       tx_request;
    logic       rx_available;
  } urtf_out_t;

  // Ring status seen by the control logic
  typedef struct packed {
    logic empty;      // pointers equal now
    logic full;       // advancing write pointer would hit read pointer
    logic empty_nxt;  // empty once this cycle's push/pop take effect
  } urtf_ring_stat_t;

endpackage

[rtl/core/urtf_ring.sv]
// One ring FIFO: read/write pointers, byte store and registered read data.
// Depends on urtf_pkg.
module urtf_ring (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     push,
  input  logic [7:0]               push_data,
  input  logic                     pop,
  output urtf_pkg::urtf_ring_stat_t stat,
  output logic [7:0]               rd_data
);
  import urtf_pkg::*;

  localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(FIFO_DEPTH - 1);
  localparam logic [PTR_W-1:0] ONE_SLOT  = PTR_W'(1);

  logic [7:0]       mem [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [PTR_W-1:0] wr_adv, rd_adv;
  logic [7:0]       rd_data_r;

  // Pointer advance with wrap
  assign wr_adv = (wr_ptr_r == LAST_SLOT) ? '0 : wr_ptr_r + ONE_SLOT;
  assign rd_adv = (rd_ptr_r == LAST_SLOT) ? '0 : rd_ptr_r + ONE_SLOT;

  assign wr_ptr_nxt = push ? wr_adv : wr_ptr_r;
  assign rd_ptr_nxt = pop  ? rd_adv : rd_ptr_r;

  // Status
  assign stat.empty     = (wr_ptr_r == rd_ptr_r);
  assign stat.full      = (wr_adv == rd_ptr_r);
  assign stat.empty_nxt = (wr_ptr_nxt == rd_ptr_nxt);

  // Pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
    end
  end

  // Byte store, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_data;
    end
    if (pop) begin
      rd_data_r <= mem[rd_ptr_r];
    end
  end

  assign rd_data = rd_data_r;

endmodule

[rtl/core/uart_rx_tx_ring_fifo_echo_top.sv]
// Top level of the buffered serial port: event decode, echo register,
// transmit-request flag and result register. Depends on urtf_pkg, urtf_ring.
// The result strobe is registered and comes in the cycle after the start edge.
// Throughput: one event per cycle; busy stays low, each ring has one
// write and one read port and an event touches at most one side of each.
// Results are never held off; each is shown for one cycle on out_valid.
// Reset (synchronous, rst_n low): rings empty, tx_request 1, echo on.
module uart_rx_tx_ring_fifo_echo_top (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  urtf_pkg::urtf_in_t  in_item,
  output logic                out_valid,
  output urtf_pkg::urtf_out_t out_item,
  input  logic                cfg_we,
  input  logic                cfg_wdata
);
  import urtf_pkg::*;

  urtf_ring_stat_t rx_stat, tx_stat;
  logic [7:0]      rx_rd_data, tx_rd_data;

  logic acc, errored;
  logic is_wr, is_rd, is_line, is_txr;
  logic rx_push, rx_pop, tx_push, tx_pop;
  logic host_wr_ok, accepted_nxt;

  logic echo_r;
  logic tx_req_r, tx_req_nxt;
  logic out_valid_r;
  logic accepted_r, rx_pop_r, tx_pop_r;

  assign busy = 1'b0;
  assign acc  = start & ~busy;

  // Event decode
  assign is_wr   = (in_item.func == FN_HOST_WR);
  assign is_rd   = (in_item.func == FN_HOST_RD);
  assign is_line = (in_item.func == FN_LINE_RX);
  assign is_txr  = (in_item.func == FN_TX_READY);
  assign errored = in_item.frame_error | in_item.overrun_error | in_item.parity_error;

  // Push/pop decisions; echo copy dropped when tx ring is full
  assign host_wr_ok   = acc & is_wr & ~tx_stat.full;
  assign rx_push      = acc & is_line & ~errored & ~rx_stat.full;
  assign rx_pop       = acc & is_rd & ~rx_stat.empty;
  assign tx_push      = host_wr_ok | (rx_push & echo_r & ~tx_stat.full);
  assign tx_pop       = acc & is_txr & ~tx_stat.empty;
  assign accepted_nxt = host_wr_ok | rx_pop | rx_push;

  // Transmit request: set on any tx push, cleared when tx ready leaves the ring empty
  always_comb begin
    tx_req_nxt = tx_req_r;
    if (tx_push) begin
      tx_req_nxt = 1'b1;
    end else if (acc && is_txr && tx_stat.empty_nxt) begin
      tx_req_nxt = 1'b0;
    end
  end

  urtf_ring u_rx_ring (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (rx_push),
    .push_data (in_item.data_in),
    .pop       (rx_pop),
    .stat      (rx_stat),
    .rd_data   (rx_rd_data)
  );

  urtf_ring u_tx_ring (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (tx_push),
    .push_data (in_item.data_in),
    .pop       (tx_pop),
    .stat      (tx_stat),
    .rd_data   (tx_rd_data)
  );

  // Control registers and result flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      echo_r      <= 1'b1;
      tx_req_r    <= 1'b1;
      out_valid_r <= 1'b0;
      accepted_r  <= 1'b0;
      rx_pop_r    <= 1'b0;
      tx_pop_r    <= 1'b0;
    end else begin
      if (cfg_we) begin
        echo_r <= cfg_wdata;
      end
      tx_req_r    <= tx_req_nxt;
      out_valid_r <= acc;
      accepted_r  <= accepted_nxt;
      rx_pop_r    <= rx_pop;
      tx_pop_r    <= tx_pop;
    end
  end

  // Result transaction; flag and level fields read the post-event state
  assign out_valid             = out_valid_r;
  assign out_item.accepted     = accepted_r;
  assign out_item.rx_data      = rx_pop_r ? rx_rd_data : 8'd0;
  assign out_item.tx_valid     = tx_pop_r;
  assign out_item.tx_data      = tx_pop_r ? tx_rd_data : 8'd0;
  assign out_item.tx_request   = tx_req_r;
  assign out_item.rx_available = ~rx_stat.empty;

endmodule

[bench/tb_uart_rx_tx_ring_fifo_echo_top.sv]
// Self-checking bench for the buffered serial port FIFO block: directed events,
// ring floods and weighted random traffic checked against an in-bench predictor.
// Depends on urtf_pkg and uart_rx_tx_ring_fifo_echo_top.
`timescale 1ns / 1ps

module tb_uart_rx_tx_ring_fifo_echo_top;
  import urtf_pkg::*;

  localparam int CLK_PERIOD  = 12;
  localparam int STALL_LIMIT = 1000;

  // Predicts each result from the two rings and the echo setting, then
  // compares it with what the block returns
  class echo_fifo_scoreboard;
    logic [7:0]  rx_ring [FIFO_DEPTH];
    logic [7:0]  tx_ring [FIFO_DEPTH];
    int unsigned rx_wr, rx_rd, tx_wr, tx_rd;
    bit          tx_req;
    bit          echo_on;
    urtf_out_t   expected_q[$];
    int          errors;
    int          results_seen;

    function new();
      rx_wr = 0; rx_rd = 0; tx_wr = 0; tx_rd = 0;
      tx_req = 1'b1;
      echo_on = 1'b1;
      errors = 0;
      results_seen = 0;
    endfunction

    function int unsigned bump(int unsigned p);
      return (p + 1 == FIFO_DEPTH) ? 0 : p + 1;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    // Push onto the transmit ring; a full ring leaves everything as it was
    function bit push_tx(logic [7:0] b);
      if (bump(tx_wr) == tx_rd) return 1'b0;
      tx_ring[tx_wr] = b;
      tx_wr = bump(tx_wr);
      tx_req = 1'b1;
      return 1'b1;
    endfunction

    // Work out the result of one accepted input transaction
    function void note_event(urtf_in_t it);
      urtf_out_t want;
      want = '0;
      case (it.func)
        FN_HOST_WR: begin
          want.accepted = push_tx(it.data_in);
        end
        FN_HOST_RD: begin
          if (rx_wr != rx_rd) begin
            want.rx_data  = rx_ring[rx_rd];
            rx_rd         = bump(rx_rd);
            want.accepted = 1'b1;
          end
        end
        FN_LINE_RX: begin
          // errored bytes and bytes hitting a full ring are dropped, no echo
          if (!(it.frame_error | it.overrun_error | it.parity_error) &&
              bump(rx_wr) != rx_rd) begin
            rx_ring[rx_wr] = it.data_in;
            rx_wr          = bump(rx_wr);
            want.accepted  = 1'b1;
            if (echo_on) void'(push_tx(it.data_in));
          end
        end
        default: begin
          if (tx_wr != tx_rd) begin
            want.tx_data  = tx_ring[tx_rd];
            tx_rd         = bump(tx_rd);
            want.tx_valid = 1'b1;
          end
          if (tx_wr == tx_rd) tx_req = 1'b0;
        end
      endcase
      want.tx_request   = tx_req;
      want.rx_available = (rx_wr != rx_rd);
      expected_q.push_back(want);
    endfunction

    task report(string field, logic [7:0] got_v, logic [7:0] want_v);
      $display("mismatch: result %0d field %s got 0x%h want 0x%h",
               results_seen, field, got_v, want_v);
      errors++;
    endtask

    task check_result(urtf_out_t got);
      urtf_out_t want;
      results_seen++;
      if (expected_q.size() == 0) begin
        report("unexpected_result", got[7:0], 8'h00);
        return;
      end
      want = expected_q.pop_front();
      if (got.accepted !== want.accepted)
        report("accepted", 8'(got.accepted), 8'(want.accepted));
      if (got.rx_data !== want.rx_data)
        report("rx_data", got.rx_data, want.rx_data);
      if (got.tx_valid !== want.tx_valid)
        report("tx_valid", 8'(got.tx_valid), 8'(want.tx_valid));
      if (got.tx_data !== want.tx_data)
        report("tx_data", got.tx_data, want.tx_data);
      if (got.tx_request !== want.tx_request)
        report("tx_request", 8'(got.tx_request), 8'(want.tx_request));
      if (got.rx_available !== want.rx_available)
        report("rx_available", 8'(got.rx_available), 8'(want.rx_available));
    endtask
  endclass

  logic      clk;
  logic      rst_n;
  logic      start;
  logic      busy;
  urtf_in_t  in_item;
  logic      out_valid;
  urtf_out_t out_item;
  logic      cfg_we;
  logic      cfg_wdata;

  echo_fifo_scoreboard sb = new();
  int stall_cycles = 0;
  int burst_left   = 0;
  bit gaps_on      = 1'b1;

  uart_rx_tx_ring_fifo_echo_top u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // Monitor: check results first, then record the transaction taken this edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid) sb.check_result(out_item);
      if (start && !busy) sb.note_event(in_item);
      if (cfg_we) sb.echo_on = cfg_wdata;
    end
  end

  // Watchdog on cycles with no transaction in either direction
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid || (start && !busy)) stall_cycles = 0;
      else stall_cycles++;
      if (stall_cycles == STALL_LIMIT) begin
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  function automatic urtf_in_t mk_event(logic [1:0] f, logic [7:0] d, logic [2:0] errs);
    urtf_in_t it;
    it.func          = f;
    it.data_in       = d;
    it.frame_error   = errs[2];
    it.overrun_error = errs[1];
    it.parity_error  = errs[0];
    return it;
  endfunction

  // Random event; line bytes mostly clean, ignored fields are noise
  function automatic urtf_in_t rand_event(logic [1:0] f);
    logic [2:0] errs;
    if (f == FN_LINE_RX)
      errs = ($urandom_range(0, 7) == 0) ? 3'($urandom_range(1, 7)) : 3'b000;
    else
      errs = 3'($urandom_range(0, 7));
    return mk_event(f, 8'($urandom_range(0, 255)), errs);
  endfunction

  function automatic logic [1:0] pick_event(int w_wr, int w_rd, int w_rx, int w_tx);
    int r;
    r = $urandom_range(0, w_wr + w_rd + w_rx + w_tx - 1);
    if (r < w_wr) return FN_HOST_WR;
    if (r < w_wr + w_rd) return FN_HOST_RD;
    if (r < w_wr + w_rd + w_rx) return FN_LINE_RX;
    return FN_TX_READY;
  endfunction

  task automatic hold_off(int n);
    repeat (n) begin
      @(negedge clk);
      start <= 1'b0;
    end
  endtask

  task automatic send_event(urtf_in_t it);
    @(negedge clk);
    start   <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (busy !== 1'b0);
  endtask

  // Sender works in bursts with random gaps between them
  task automatic send_paced(urtf_in_t it);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      if (gaps_on && $urandom_range(0, 3) != 0) hold_off($urandom_range(1, 6));
    end
    burst_left--;
    send_event(it);
  endtask

  // Stop sending and wait for every outstanding result
  task automatic wait_drained();
    @(negedge clk);
    start <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_echo(bit v);
    wait_drained();
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  initial begin
    int w_wr, w_rd, w_rx, w_tx;
    rst_n     = 1'b0;
    start     = 1'b0;
    in_item   = '0;
    cfg_we    = 1'b0;
    cfg_wdata = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: empty pops, write extremes, each error flag, echo paths
    write_echo(1'b1);
    send_event(mk_event(FN_HOST_RD, 8'hFF, 3'b111));
    send_event(mk_event(FN_TX_READY, 8'hFF, 3'b111));
    send_event(mk_event(FN_HOST_WR, 8'h00, 3'b000));
    send_event(mk_event(FN_HOST_WR, 8'hFF, 3'b111));
    send_event(mk_event(FN_LINE_RX, 8'h5A, 3'b100));
    send_event(mk_event(FN_LINE_RX, 8'h5A, 3'b010));
    send_event(mk_event(FN_LINE_RX, 8'h5A, 3'b001));
    send_event(mk_event(FN_LINE_RX, 8'hC3, 3'b111));
    send_event(mk_event(FN_LINE_RX, 8'h00, 3'b000));
    send_event(mk_event(FN_LINE_RX, 8'hFF, 3'b000));
    repeat (3) send_event(mk_event(FN_HOST_RD, 8'h00, 3'b000));
    repeat (5) send_event(mk_event(FN_TX_READY, 8'h00, 3'b000));
    write_echo(1'b0);
    send_event(mk_event(FN_LINE_RX, 8'h81, 3'b000));
    send_event(mk_event(FN_TX_READY, 8'h00, 3'b000));
    send_event(mk_event(FN_HOST_RD, 8'h00, 3'b000));
    write_echo(1'b1);

    // Flood: fill the receive ring and, by echo, the transmit ring past full
    repeat (135) send_paced(mk_event(FN_LINE_RX, 8'($urandom_range(0, 255)), 3'b000));
    repeat (135) send_paced(rand_event(FN_HOST_WR));
    repeat (135) send_paced(rand_event(FN_HOST_RD));
    repeat (135) send_paced(rand_event(FN_TX_READY));

    // Mixed phases with their own event mix; echo is on in even phases, off in odd ones
    for (int ph = 0; ph < 8; ph++) begin
      write_echo(ph[0] == 1'b0);
      gaps_on = (ph != 3);
      w_wr = $urandom_range(1, 10);
      w_rd = $urandom_range(1, 10);
      w_rx = $urandom_range(1, 12);
      w_tx = $urandom_range(1, 10);
      repeat (90) send_paced(rand_event(pick_event(w_wr, w_rd, w_rx, w_tx)));
    end

    wait_drained();
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
